// File: rtl/fgn_pkg.sv
package fgn_pkg;

  // Fraction width of lattice coordinates and fade values
  localparam int FRAC = 16;
  // Shared multiplier operand width (signed)
  localparam int MUL_W = 26;

  // Operation codes
  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_PIXEL = 1'b1;

  // Configuration register indexes
  localparam logic [2:0] REG_INV_SCALE    = 3'd0;
  localparam logic [2:0] REG_OCTAVE_COUNT = 3'd1;
  localparam logic [2:0] REG_PERSISTENCE  = 3'd2;
  localparam logic [2:0] REG_OCTAVE_GAIN  = 3'd3;
  localparam logic [2:0] REG_OFFSET_X     = 3'd4;
  localparam logic [2:0] REG_OFFSET_Y     = 3'd5;

  typedef struct packed {
    logic        op;
    logic [7:0]  perm_index;
    logic [7:0]  perm_value;
    logic [15:0] col;
    logic [15:0] row;
  } in_t;

  typedef struct packed {
    logic [15:0] noise_value;
    logic [15:0] out_col;
    logic [15:0] out_row;
  } out_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_PX,
    S_POS,
    S_FADE,
    S_HASH,
    S_LERP,
    S_ACC,
    S_AMP,
    S_FREQ,
    S_FIN,
    S_DIV,
    S_DONE
  } state_t;

  // Gradient for one of four diagonal directions
  function automatic logic signed [18:0] grad(input logic [7:0] h,
                                              input logic signed [18:0] dx,
                                              input logic signed [18:0] dy);
    logic signed [18:0] gu;
    logic signed [18:0] gv;
    gu = h[0] ? -dx : dx;
    gv = h[1] ? -dy : dy;
    return gu + gv;
  endfunction

endpackage

// File: rtl/fractal_gradient_noise_2d_top.sv
// Pixel request: the result takes N octaves, N = octaves (1..MAX_OCTAVES), and then the 16-step division;
// the division is skipped when the output saturates.
// One pixel in flight; the next request is taken the cycle after the result is registered.
// Each octave runs 28 steps through one shared 26x26 multiplier and the single table port.
// Load request: written into the table on accept, no result.
// Reset (rst, synchronous) returns control and configuration to defaults; the table is not cleared.
module fractal_gradient_noise_2d_top
  import fgn_pkg::*;
#(
  parameter int MAX_OCTAVES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_t         in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_t        out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  localparam int OCT_W = $clog2(MAX_OCTAVES + 1);
  localparam int TOT_W = 17 + OCT_W;
  localparam int SUM_W = 38 + OCT_W;
  localparam int REM_W = TOT_W + 17;

  // configuration
  logic [23:0] inv_scale;
  logic [3:0]  octave_count;
  logic [15:0] persistence;
  logic [15:0] octave_gain;
  logic [15:0] offset_x;
  logic [15:0] offset_y;

  // control
  state_t           state, state_next;
  logic [3:0]       stp, stp_next;
  logic             ax, ax_next;
  logic [OCT_W-1:0] oct_idx;
  logic [OCT_W-1:0] n_oct;
  logic [OCT_W-1:0] n_oct_next;

  // datapath
  logic [15:0]             col_r, row_r;
  logic [48:0]             px, py;
  logic [47:0]             freq;
  logic [39:0]             freq_lo;
  logic [16:0]             amp;
  logic [TOT_W-1:0]        total;
  logic signed [SUM_W-1:0] sum;
  logic [43:0]             pacc;
  logic [15:0]             xf, yf;
  logic [7:0]              xl, yl;
  logic [15:0]             tp, t3r, t4r;
  logic [16:0]             u, v;
  logic [7:0]              pya, pyb, aa, ab, ba, bb;
  logic signed [18:0]      x1, x2, val;
  logic [REM_W-1:0]        rem, dsh;
  logic [15:0]             quo;
  logic [15:0]             res;

  // table memory
  logic [7:0] perm [256];
  logic [7:0] mem_addr;
  logic       mem_we;
  logic [7:0] mem_rd;

  // shared multiplier
  logic signed [MUL_W-1:0]   ma, mb;
  logic signed [2*MUL_W-1:0] mp;
  assign mp = ma * mb;

  logic accept;
  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  // operand helpers
  logic [16:0]        sx, sy;
  logic [48:0]        a_src;
  logic [15:0]        tf;
  logic signed [18:0] dx0, dx1, dy0, dy1;
  logic signed [18:0] ga0, gb0, ga1, gb1;
  logic signed [19:0] ldiff;
  logic [43:0]        pfin;
  logic signed [21:0] fr;
  logic [16:0]        fclamp;
  logic signed [19:0] lsum;
  logic [63:0]        f64;
  logic signed [SUM_W-1:0] num;
  logic [REM_W-1:0]   den;

  assign sx    = {1'b0, offset_x} + {1'b0, col_r};
  assign sy    = {1'b0, offset_y} + {1'b0, row_r};
  assign a_src = ax ? py : px;
  assign tf    = ax ? yf : xf;
  assign dx0   = {3'b000, xf};
  assign dx1   = dx0 - 19'sd65536;
  assign dy0   = {3'b000, yf};
  assign dy1   = dy0 - 19'sd65536;
  assign ga0   = grad(aa, dx0, dy0);
  assign gb0   = grad(ba, dx1, dy0);
  assign ga1   = grad(ab, dx0, dy1);
  assign gb1   = grad(bb, dx1, dy1);
  assign pfin  = pacc + {mp[21:0], 22'b0};
  assign f64   = {mp[39:0], 24'b0} + {24'b0, freq_lo};
  assign num   = sum + $signed({{(SUM_W-TOT_W-16){1'b0}}, total, 16'b0});
  assign den   = {total, 17'b0};

  // quintic fade from t3, t4 and the t5 product, clamped to 0..1
  always_comb begin
    fr = 22'sd10 * $signed({6'b0, t3r}) - 22'sd15 * $signed({6'b0, t4r})
       + 22'sd6 * $signed({6'b0, mp[31:16]});
    if (fr < 0) begin
      fclamp = 17'd0;
    end else if (fr > 22'sd65536) begin
      fclamp = 17'd65536;
    end else begin
      fclamp = fr[16:0];
    end
  end

  // lerp: a + floor((b - a) * t / 2^16)
  always_comb begin
    case (stp)
      4'd0:    lsum = {ga0[18], ga0} + mp[35:16];
      4'd1:    lsum = {ga1[18], ga1} + mp[35:16];
      default: lsum = {x1[18], x1} + mp[35:16];
    endcase
  end

  // octave count clamp
  always_comb begin
    if (octave_count == 4'd0) begin
      n_oct_next = OCT_W'(1);
    end else if (int'(octave_count) > MAX_OCTAVES) begin
      n_oct_next = OCT_W'(MAX_OCTAVES);
    end else begin
      n_oct_next = OCT_W'(octave_count);
    end
  end

  // sequencer: next state, multiplier operands, table address
  always_comb begin
    state_next = state;
    stp_next   = stp;
    ax_next    = ax;
    ma         = '0;
    mb         = '0;
    mem_addr   = in_data.perm_index;
    mem_we     = 1'b0;
    ldiff      = '0;
    case (state)
      S_IDLE: begin
        mem_we = accept && (in_data.op == OP_LOAD);
        if (accept && in_data.op == OP_PIXEL) begin
          state_next = S_PX;
          ax_next    = 1'b0;
        end
      end
      S_PX: begin
        ma = {9'b0, ax ? sy : sx};
        mb = {2'b0, inv_scale};
        if (ax) begin
          state_next = S_POS;
          ax_next    = 1'b0;
          stp_next   = 4'd0;
        end else begin
          ax_next = 1'b1;
        end
      end
      S_POS: begin
        case (stp)
          4'd0: begin
            ma = {4'b0, a_src[21:0]};
            mb = {4'b0, freq[21:0]};
          end
          4'd1: begin
            ma = {4'b0, a_src[43:22]};
            mb = {4'b0, freq[21:0]};
          end
          default: begin
            ma = {4'b0, a_src[21:0]};
            mb = {4'b0, freq[43:22]};
          end
        endcase
        if (stp == 4'd2) begin
          stp_next = 4'd0;
          ax_next  = ~ax;
          if (ax) state_next = S_FADE;
        end else begin
          stp_next = stp + 4'd1;
        end
      end
      S_FADE: begin
        ma = {10'b0, (stp == 4'd0) ? tf : tp};
        mb = {10'b0, tf};
        if (stp == 4'd3) begin
          stp_next = 4'd0;
          ax_next  = ~ax;
          if (ax) state_next = S_HASH;
        end else begin
          stp_next = stp + 4'd1;
        end
      end
      S_HASH: begin
        case (stp)
          4'd0:    mem_addr = yl;
          4'd1:    mem_addr = yl + 8'd1;
          4'd2:    mem_addr = xl + pya;
          4'd3:    mem_addr = xl + pyb;
          4'd4:    mem_addr = xl + 8'd1 + pya;
          default: mem_addr = xl + 8'd1 + pyb;
        endcase
        if (stp == 4'd6) begin
          stp_next   = 4'd0;
          state_next = S_LERP;
        end else begin
          stp_next = stp + 4'd1;
        end
      end
      S_LERP: begin
        case (stp)
          4'd0: begin
            ldiff = {gb0[18], gb0} - {ga0[18], ga0};
            mb    = {9'b0, u};
          end
          4'd1: begin
            ldiff = {gb1[18], gb1} - {ga1[18], ga1};
            mb    = {9'b0, u};
          end
          default: begin
            ldiff = {x2[18], x2} - {x1[18], x1};
            mb    = {9'b0, v};
          end
        endcase
        ma = {{(MUL_W-20){ldiff[19]}}, ldiff};
        if (stp == 4'd2) begin
          stp_next   = 4'd0;
          state_next = S_ACC;
        end else begin
          stp_next = stp + 4'd1;
        end
      end
      S_ACC: begin
        ma = {{(MUL_W-19){val[18]}}, val};
        mb = {9'b0, amp};
        state_next = S_AMP;
      end
      S_AMP: begin
        ma = {9'b0, amp};
        mb = {10'b0, persistence};
        state_next = S_FREQ;
        stp_next   = 4'd0;
      end
      S_FREQ: begin
        ma = {2'b0, (stp == 4'd0) ? freq[23:0] : freq[47:24]};
        mb = {10'b0, octave_gain};
        if (stp == 4'd1) begin
          stp_next = 4'd0;
          ax_next  = 1'b0;
          if (oct_idx + OCT_W'(1) == n_oct) begin
            state_next = S_FIN;
          end else begin
            state_next = S_POS;
          end
        end else begin
          stp_next = 4'd1;
        end
      end
      S_FIN: begin
        stp_next = 4'd0;
        if (num <= 0 || num[REM_W-1:0] >= den) begin
          state_next = S_DONE;
        end else begin
          state_next = S_DIV;
        end
      end
      S_DIV: begin
        if (stp == 4'd15) begin
          state_next = S_DONE;
        end
        stp_next = stp + 4'd1;
      end
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // control registers and configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      stp          <= 4'd0;
      ax           <= 1'b0;
      oct_idx      <= '0;
      n_oct        <= OCT_W'(1);
      out_valid    <= 1'b0;
      inv_scale    <= 24'd4096;
      octave_count <= 4'd4;
      persistence  <= 16'd32768;
      octave_gain  <= 16'd8192;
      offset_x     <= 16'd0;
      offset_y     <= 16'd0;
    end else begin
      state <= state_next;
      stp   <= stp_next;
      ax    <= ax_next;
      if (accept && in_data.op == OP_PIXEL) begin
        oct_idx <= '0;
        n_oct   <= n_oct_next;
      end else if (state == S_FREQ && stp == 4'd1) begin
        oct_idx <= oct_idx + OCT_W'(1);
      end
      if (state == S_DONE && (!out_valid || out_ready)) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_INV_SCALE:    inv_scale    <= cfg_data;
          REG_OCTAVE_COUNT: octave_count <= cfg_data[3:0];
          REG_PERSISTENCE:  persistence  <= cfg_data[15:0];
          REG_OCTAVE_GAIN:  octave_gain  <= cfg_data[15:0];
          REG_OFFSET_X:     offset_x     <= cfg_data[15:0];
          REG_OFFSET_Y:     offset_y     <= cfg_data[15:0];
          default: ;
        endcase
      end
    end
  end

  // permutation table, one port
  always_ff @(posedge clk) begin
    if (mem_we) perm[mem_addr] <= in_data.perm_value;
    mem_rd <= perm[mem_addr];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (accept && in_data.op == OP_PIXEL) begin
          col_r <= in_data.col;
          row_r <= in_data.row;
          freq  <= 48'd4096;
          amp   <= 17'd65536;
          total <= '0;
          sum   <= '0;
        end
      end
      S_PX: begin
        if (ax) py <= {mp[40:0], 8'b0};
        else    px <= {mp[40:0], 8'b0};
      end
      S_POS: begin
        if (stp == 4'd0) begin
          pacc <= mp[43:0];
        end else if (stp == 4'd1) begin
          pacc <= pfin;
        end else if (ax) begin
          yl <= pfin[43:36];
          yf <= pfin[35:20];
        end else begin
          xl <= pfin[43:36];
          xf <= pfin[35:20];
        end
      end
      S_FADE: begin
        tp <= mp[31:16];
        if (stp == 4'd1) t3r <= mp[31:16];
        if (stp == 4'd2) t4r <= mp[31:16];
        if (stp == 4'd3) begin
          if (ax) v <= fclamp;
          else    u <= fclamp;
        end
      end
      S_HASH: begin
        case (stp)
          4'd1: pya <= mem_rd;
          4'd2: pyb <= mem_rd;
          4'd3: aa  <= mem_rd;
          4'd4: ab  <= mem_rd;
          4'd5: ba  <= mem_rd;
          4'd6: bb  <= mem_rd;
          default: ;
        endcase
      end
      S_LERP: begin
        case (stp)
          4'd0:    x1  <= lsum[18:0];
          4'd1:    x2  <= lsum[18:0];
          default: val <= lsum[18:0];
        endcase
      end
      S_ACC: begin
        sum   <= sum + mp[SUM_W-1:0];
        total <= total + TOT_W'(amp);
      end
      S_AMP: amp <= mp[32:16];
      S_FREQ: begin
        if (stp == 4'd0) freq_lo <= mp[39:0];
        else             freq    <= f64[59:12];
      end
      S_FIN: begin
        rem <= num[REM_W-1:0];
        dsh <= {1'b0, total, 16'b0};
        quo <= 16'd0;
        if (num <= 0) begin
          res <= 16'd0;
        end else if (num[REM_W-1:0] >= den) begin
          res <= 16'hFFFF;
        end
      end
      S_DIV: begin
        if (rem >= dsh) begin
          rem <= rem - dsh;
          quo <= {quo[14:0], 1'b1};
          if (stp == 4'd15) res <= {quo[14:0], 1'b1};
        end else begin
          quo <= {quo[14:0], 1'b0};
          if (stp == 4'd15) res <= {quo[14:0], 1'b0};
        end
        dsh <= dsh >> 1;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          out_data.noise_value <= res;
          out_data.out_col     <= col_r;
          out_data.out_row     <= row_r;
        end
      end
      default: ;
    endcase
  end

  // pixel request always starts the sequencer
  a_pixel_starts: assert property (@(posedge clk) disable iff (rst)
    (accept && in_data.op == OP_PIXEL) |=> (state == S_PX))
    else $error("pixel request did not start the sequencer");

  // octave index never passes the clamped count
  a_oct_bound: assert property (@(posedge clk) disable iff (rst)
    (state != S_IDLE) |-> (oct_idx <= n_oct))
    else $error("octave index overran the octave count");

  // restoring division keeps the remainder below twice the divisor step
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> (rem < {dsh, 1'b0}))
    else $error("division remainder out of range");

  // result is loaded only when the output register is free
  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_valid && !out_ready) |=> (state == S_DONE))
    else $error("result left while output register was full");

endmodule
